/* rtl/sorted_software_timer_queue_top_defines.svh */
// assertion macros shared by the timer queue rtl
// no dependencies
`ifndef SORTED_SOFTWARE_TIMER_QUEUE_TOP_DEFINES_SVH
`define SORTED_SOFTWARE_TIMER_QUEUE_TOP_DEFINES_SVH

// clocked assertion with asynchronous active-low reset disable
`define STQ_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// default clock and reset names
`define STQ_ASSERT(lbl, prop, msg) \
  `STQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* rtl/stq_pkg.sv */
// types and constants of the sorted timer queue
// no dependencies
package stq_pkg;

  localparam int unsigned DefaultDepth = 16;

  localparam logic [1:0] ActStartPeriodic = 2'd0;
  localparam logic [1:0] ActStartOneShot  = 2'd1;
  localparam logic [1:0] ActExpire        = 2'd2;
  localparam logic [1:0] ActClear         = 2'd3;

  localparam logic [1:0] KindStarted  = 2'd0;
  localparam logic [1:0] KindFired    = 2'd1;
  localparam logic [1:0] KindRejected = 2'd2;
  localparam logic [1:0] KindNone     = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         handler_tag;
    logic [31:0]        period;
    logic signed [31:0] arg_one;
    logic signed [31:0] arg_two;
    logic signed [31:0] arg_three;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         fired_tag;
    logic signed [31:0] fired_arg_one;
    logic signed [31:0] fired_arg_two;
    logic signed [31:0] fired_arg_three;
    logic [31:0]        next_delay;
    logic [4:0]         pending_count;
    logic               last;
  } result_t;

  // one held timer
  typedef struct packed {
    logic [31:0] due;
    logic [31:0] period;
    logic        once;
    logic [7:0]  tag;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] a3;
  } entry_t;

  // one fired timer kept for reinsert and reporting
  typedef struct packed {
    logic [31:0] period;
    logic        once;
    logic [7:0]  tag;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] a3;
  } fired_t;

  typedef struct packed {
    logic       ins_en;
    logic       ins_from_buf;
    logic       pop;
    logic       clear;
    logic       buf_we;
    logic       out_direct;
    logic       out_from_buf;
    logic       out_last;
    logic [1:0] out_kind;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic one_left;
    logic full;
    logic head_zero;
    logic buf_once;
  } stat_t;

endpackage

/* rtl/stq_ram.sv */
// generic single-port ram with registered read
// no dependencies
module stq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/stq_datapath.sv */
// sorted cell row, fired-timer buffer and result register
// depends on stq_pkg, stq_ram and the assertion macro header
`include "sorted_software_timer_queue_top_defines.svh"
module stq_datapath #(
  parameter int unsigned DEPTH = stq_pkg::DefaultDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  stq_pkg::cmd_t            cmd_i,
  input  logic [$clog2(DEPTH)-1:0] buf_addr_i,
  input  stq_pkg::item_t           item_i,
  output stq_pkg::stat_t           stat_o,
  output logic                     res_valid_o,
  output stq_pkg::result_t         res_o
);
  import stq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t           cells_q [DEPTH];
  entry_t           cells_d [DEPTH];
  logic [DEPTH-1:0] lt;
  logic [CW-1:0]    count_q, count_d;
  entry_t           ne;
  fired_t           buf_wdata, buf_rdata;
  logic             res_valid_q;
  result_t          res_q;

  stq_ram #(.Width($bits(fired_t)), .Depth(DEPTH)) u_buf (
    .clk_i   (clk_i),
    .we_i    (cmd_i.buf_we),
    .addr_i  (buf_addr_i),
    .wdata_i (buf_wdata),
    .rdata_o (buf_rdata)
  );

  assign buf_wdata = '{period: cells_q[0].period, once: cells_q[0].once,
                       tag: cells_q[0].tag, a1: cells_q[0].a1,
                       a2: cells_q[0].a2, a3: cells_q[0].a3};

  // entry to insert, from the accepted beat or the fired buffer
  always_comb begin
    if (cmd_i.ins_from_buf) begin
      ne = '{due: buf_rdata.period, period: buf_rdata.period, once: 1'b0,
             tag: buf_rdata.tag, a1: buf_rdata.a1, a2: buf_rdata.a2, a3: buf_rdata.a3};
    end else begin
      ne = '{due: item_i.period, period: item_i.period,
             once: (item_i.action == ActStartOneShot), tag: item_i.handler_tag,
             a1: item_i.arg_one, a2: item_i.arg_two, a3: item_i.arg_three};
    end
  end

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    assign lt[gi] = (CW'(gi) < count_q) && (cells_q[gi].due < ne.due);

    always_comb begin
      cells_d[gi] = cells_q[gi];
      if (cmd_i.pop) begin
        if (gi < DEPTH - 1) begin
          cells_d[gi] = cells_q[(gi + 1) % DEPTH];
          if (cells_q[(gi + 1) % DEPTH].due >= cells_q[0].due) begin
            cells_d[gi].due = cells_q[(gi + 1) % DEPTH].due - cells_q[0].due;
          end
        end
      end else if (cmd_i.ins_en) begin
        if (!lt[gi]) begin
          if (gi == 0) begin
            cells_d[gi] = ne;
          end else if (lt[(gi + DEPTH - 1) % DEPTH]) begin
            cells_d[gi] = ne;
          end else begin
            cells_d[gi] = cells_q[(gi + DEPTH - 1) % DEPTH];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      cells_q[gi] <= cells_d[gi];
    end
  end

  always_comb begin
    count_d = count_q;
    priority if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
    end else if (cmd_i.ins_en) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= cmd_i.out_direct | cmd_i.out_from_buf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_direct || cmd_i.out_from_buf) begin
      res_q.kind            <= cmd_i.out_direct ? cmd_i.out_kind : KindFired;
      res_q.fired_tag       <= cmd_i.out_direct ? 8'd0 : buf_rdata.tag;
      res_q.fired_arg_one   <= cmd_i.out_direct ? 32'sd0 : buf_rdata.a1;
      res_q.fired_arg_two   <= cmd_i.out_direct ? 32'sd0 : buf_rdata.a2;
      res_q.fired_arg_three <= cmd_i.out_direct ? 32'sd0 : buf_rdata.a3;
      res_q.next_delay      <= (count_q != '0) ? cells_q[0].due : 32'd0;
      res_q.pending_count   <= 5'(count_q);
      res_q.last            <= cmd_i.out_last;
    end
  end

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.one_left  = (count_q == CW'(1));
  assign stat_o.full      = (count_q == CW'(DEPTH));
  assign stat_o.head_zero = (cells_q[1 % DEPTH].due == cells_q[0].due);
  assign stat_o.buf_once  = buf_rdata.once;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `STQ_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "entry count above depth")
  `STQ_ASSERT(a_pop_nonempty, cmd_i.pop |-> count_q != '0, "pop on empty list")
  `STQ_ASSERT(a_ins_not_full, cmd_i.ins_en |-> count_q != CW'(DEPTH), "insert when full")
endmodule

/* rtl/stq_ctrl.sv */
// sequencer for start, clear, expire walk, reinsert and result emission
// depends on stq_pkg
module stq_ctrl #(
  parameter int unsigned DEPTH = stq_pkg::DefaultDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [1:0]               action_i,
  input  stq_pkg::stat_t           stat_i,
  output logic                     busy_o,
  output stq_pkg::cmd_t            cmd_o,
  output logic [$clog2(DEPTH)-1:0] buf_addr_o
);
  import stq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  typedef enum logic [2:0] {
    StIdle, StResp, StFire, StRbReq, StRbIns, StEmit, StDrain
  } state_e;

  state_e        state_q;
  logic [1:0]    kind_q;
  logic [AW:0]   nf_q;
  logic [AW-1:0] rptr_q;
  logic [AW:0]   eptr_q;
  logic          emit_v_q;
  logic          last_q;

  always_comb begin
    cmd_o      = '0;
    buf_addr_o = '0;
    cmd_o.out_from_buf = emit_v_q;
    cmd_o.out_last     = last_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          if ((action_i == ActStartPeriodic || action_i == ActStartOneShot) && !stat_i.full) begin
            cmd_o.ins_en = 1'b1;
          end
          cmd_o.clear = (action_i == ActClear);
        end
      end
      StResp: begin
        cmd_o.out_direct = 1'b1;
        cmd_o.out_kind   = kind_q;
        cmd_o.out_last   = 1'b1;
      end
      StFire: begin
        cmd_o.buf_we = 1'b1;
        cmd_o.pop    = 1'b1;
        buf_addr_o   = nf_q[AW-1:0];
      end
      StRbReq: buf_addr_o = rptr_q;
      StRbIns: begin
        cmd_o.ins_en       = !stat_i.buf_once;
        cmd_o.ins_from_buf = 1'b1;
      end
      StEmit: buf_addr_o = eptr_q[AW-1:0];
      StDrain: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      kind_q   <= KindNone;
      nf_q     <= '0;
      rptr_q   <= '0;
      eptr_q   <= '0;
      emit_v_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            unique case (action_i)
              ActStartPeriodic, ActStartOneShot: begin
                kind_q  <= stat_i.full ? KindRejected : KindStarted;
                state_q <= StResp;
              end
              ActClear: begin
                kind_q  <= KindNone;
                state_q <= StResp;
              end
              ActExpire: begin
                kind_q  <= KindNone;
                nf_q    <= '0;
                state_q <= stat_i.empty ? StResp : StFire;
              end
              default: state_q <= StIdle;
            endcase
          end
        end
        StResp: state_q <= StIdle;
        StFire: begin
          nf_q <= nf_q + 1'b1;
          if (stat_i.one_left || !stat_i.head_zero) begin
            rptr_q  <= nf_q[AW-1:0];
            state_q <= StRbReq;
          end
        end
        StRbReq: state_q <= StRbIns;
        StRbIns: begin
          if (rptr_q == '0) begin
            eptr_q  <= '0;
            state_q <= StEmit;
          end else begin
            rptr_q  <= rptr_q - 1'b1;
            state_q <= StRbReq;
          end
        end
        StEmit: begin
          emit_v_q <= 1'b1;
          last_q   <= (eptr_q == nf_q - 1'b1);
          eptr_q   <= eptr_q + 1'b1;
          if (eptr_q == nf_q - 1'b1) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          emit_v_q <= 1'b0;
          last_q   <= 1'b0;
          state_q  <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);
endmodule

/* rtl/sorted_software_timer_queue_top.sv */
// top level of the sorted software timer queue
// depends on stq_pkg, stq_ctrl and stq_datapath
//
// usage
// - command channel: a beat (item_i) is taken at a clock edge with start_i high and busy_o
//   low; busy_o drops in the cycle that shows the final result of that beat
// - result channel: each result sits on res_o for exactly one cycle with res_valid_o high;
//   the receiver cannot stall, so it must take every beat as it comes
// - start and clear beats: busy_o is high for one cycle after acceptance and the single
//   result is on res_o in the cycle after that
// - an expire beat that fires n timers first walks the list (one head removal and subtract
//   over the cell row per cycle), then reinserts (one read of the fired buffer ram per fired
//   timer, plus one insert for each periodic one) and then emits one result per fired timer;
//   busy_o stays high until the final result, flagged by last, is on res_o;
//   results stream back to back
// - every result of a beat carries next_delay and pending_count after the whole beat
// - reset empties the list at once; no clearing pass is needed
//
module sorted_software_timer_queue_top #(
  parameter int unsigned DEPTH = stq_pkg::DefaultDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  stq_pkg::item_t   item_i,
  output logic             busy_o,
  output logic             res_valid_o,
  output stq_pkg::result_t res_o
);
  import stq_pkg::*;

  cmd_t                     cmd;
  stat_t                    stat;
  logic [$clog2(DEPTH)-1:0] buf_addr;

  // sequencer: decides what the cell row does each cycle
  stq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .action_i   (item_i.action),
    .stat_i     (stat),
    .busy_o     (busy_o),
    .cmd_o      (cmd),
    .buf_addr_o (buf_addr)
  );

  // sorted cells, fired buffer and output register
  stq_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .buf_addr_i  (buf_addr),
    .item_i      (item_i),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );
endmodule

/* bench/stq_checker.sv */
// result checker for the sorted software timer queue: predicts every result beat
// depends on stq_pkg; watches the command and result channels of the block
`timescale 1ns / 100ps

module stq_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  stq_pkg::item_t   item_i,
  input  logic             busy_i,
  input  logic             res_valid_i,
  input  stq_pkg::result_t res_i,
  output int               fail_count_o,
  output int               pending_results_o
);
  import stq_pkg::*;

  entry_t          timer_list[DEPTH];
  int unsigned     timer_count;
  result_t         due_results[$];

  assign pending_results_o = due_results.size();

  function automatic void insert_timer(logic [31:0] per, logic once, logic [7:0] tag,
                                       logic [31:0] a1, logic [31:0] a2, logic [31:0] a3);
    int unsigned pos;
    pos = 0;
    if (timer_count >= DEPTH) return;
    while (pos < timer_count && timer_list[pos].due < per) pos++;
    for (int unsigned i = timer_count; i > pos; i--) timer_list[i] = timer_list[i-1];
    timer_list[pos] = '{due: per, period: per, once: once, tag: tag, a1: a1, a2: a2,
                        a3: a3};
    timer_count++;
  endfunction

  function automatic void predict_beat(item_t it);
    result_t outs[$];
    result_t r;
    entry_t  head;
    entry_t  rearm[$];
    r = '0;
    if (it.action == ActStartPeriodic || it.action == ActStartOneShot) begin
      r.kind = (timer_count >= DEPTH) ? KindRejected : KindStarted;
      insert_timer(it.period, it.action == ActStartOneShot, it.handler_tag,
                   it.arg_one, it.arg_two, it.arg_three);
      outs.push_back(r);
    end else if (it.action == ActClear || timer_count == 0) begin
      if (it.action == ActClear) timer_count = 0;
      r.kind = KindNone;
      outs.push_back(r);
    end else begin
      do begin
        head = timer_list[0];
        r = '0;
        r.kind = KindFired;
        r.fired_tag = head.tag;
        r.fired_arg_one = head.a1;
        r.fired_arg_two = head.a2;
        r.fired_arg_three = head.a3;
        outs.push_back(r);
        if (!head.once) rearm.push_back(head);
        for (int unsigned i = 1; i < timer_count; i++) timer_list[i-1] = timer_list[i];
        timer_count--;
        for (int unsigned i = 0; i < timer_count; i++)
          if (timer_list[i].due >= head.due) timer_list[i].due -= head.due;
      end while (timer_count > 0 && timer_list[0].due == 0);
      // innermost fired goes back first
      while (rearm.size() > 0) begin
        head = rearm.pop_back();
        insert_timer(head.period, 1'b0, head.tag, head.a1, head.a2, head.a3);
      end
    end
    foreach (outs[k]) begin
      outs[k].next_delay = timer_count > 0 ? timer_list[0].due : '0;
      outs[k].pending_count = timer_count[4:0];
      outs[k].last = (k == outs.size() - 1);
      due_results.push_back(outs[k]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      timer_count = 0;
      fail_count_o <= 0;
      due_results.delete();
    end else begin
      if (res_valid_i) begin
        if (due_results.size() == 0) begin
          $error("unexpected result beat kind %0d", res_i.kind);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = due_results.pop_front();
          if (res_i !== want) begin
            fail_count_o <= fail_count_o + 1;
            if (res_i.kind !== want.kind)
              $error("kind exp %0d got %0d", want.kind, res_i.kind);
            if (res_i.fired_tag !== want.fired_tag)
              $error("fired_tag exp %0h got %0h", want.fired_tag, res_i.fired_tag);
            if (res_i.fired_arg_one !== want.fired_arg_one)
              $error("fired_arg_one exp %0h got %0h", want.fired_arg_one,
                     res_i.fired_arg_one);
            if (res_i.fired_arg_two !== want.fired_arg_two)
              $error("fired_arg_two exp %0h got %0h", want.fired_arg_two,
                     res_i.fired_arg_two);
            if (res_i.fired_arg_three !== want.fired_arg_three)
              $error("fired_arg_three exp %0h got %0h", want.fired_arg_three,
                     res_i.fired_arg_three);
            if (res_i.next_delay !== want.next_delay)
              $error("next_delay exp %0h got %0h", want.next_delay, res_i.next_delay);
            if (res_i.pending_count !== want.pending_count)
              $error("pending_count exp %0d got %0d", want.pending_count,
                     res_i.pending_count);
            if (res_i.last !== want.last)
              $error("last exp %0b got %0b", want.last, res_i.last);
          end
        end
      end
      if (start_i && !busy_i) predict_beat(item_i);
    end
  end

endmodule

/* bench/tb_sorted_software_timer_queue_top.sv */
// stimulus and verdict for the sorted software timer queue
// depends on stq_pkg, sorted_software_timer_queue_top and stq_checker
`timescale 1ns / 100ps

module tb_sorted_software_timer_queue_top;
  import stq_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int          StallLimit = 2000;

  logic    clk_i;
  logic    rst_ni;
  logic    start_i;
  item_t   item_i;
  logic    busy_o;
  logic    res_valid_o;
  result_t res_o;
  int      fail_count;
  int      results_owed;
  int      quiet_cycles;
  bit      no_gaps;

  // 4 ns clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  sorted_software_timer_queue_top #(.DEPTH(Depth)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  stq_checker #(.DEPTH(Depth)) i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .item_i           (item_i),
    .busy_i           (busy_o),
    .res_valid_i      (res_valid_o),
    .res_i            (res_o),
    .fail_count_o     (fail_count),
    .pending_results_o(results_owed)
  );

  // watchdog: cycles with neither a command beat nor a result beat taken
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || res_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("tb_sorted_software_timer_queue_top NOT OK");
      $finish;
    end
  end

  // random word biased toward the extremes
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // one command beat, held until the block takes it; start_i stays high for a next beat
  task automatic send_beat(logic [1:0] act, logic [7:0] tag, logic [31:0] per,
                           logic [31:0] a1, logic [31:0] a2, logic [31:0] a3);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 37) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    item_i  <= '{action: act, handler_tag: tag, period: per, arg_one: a1, arg_two: a2,
                 arg_three: a3};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic send_random(int unsigned act_mix);
    logic [1:0]  act;
    logic [31:0] per;
    // mostly starts with small periods so that lists fill and fire in groups
    if ($urandom_range(0, 99) < act_mix)
      act = $urandom_range(0, 1) ? ActStartPeriodic : ActStartOneShot;
    else
      act = ($urandom_range(0, 9) == 0) ? ActClear : ActExpire;
    per = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : pick_word();
    send_beat(act, 8'($urandom()), per, pick_word(), pick_word(), pick_word());
  endtask

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    item_i  = '0;
    no_gaps = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty expire and clear, extremes, zero period, full list
    send_beat(ActExpire, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(ActClear, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(ActStartPeriodic, 8'hff, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_beat(ActStartOneShot, 8'h00, 32'hffff_ffff, 32'h0, 32'h1, 32'h8000_0000);
    send_beat(ActStartOneShot, 8'h5a, 32'h0, 32'h1234_5678, 32'h0, 32'h0);
    send_beat(ActExpire, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(ActExpire, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0);
    for (int i = 0; i < 17; i++)
      send_beat(i[0] ? ActStartOneShot : ActStartPeriodic, 8'(i), 32'd3, i, -i, ~i);
    send_beat(ActExpire, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(ActClear, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0);

    // random part, one stretch without any gaps
    for (int n = 0; n < 420; n++) begin
      no_gaps = (n >= 150 && n < 230);
      send_random((n % 100 < 50) ? 75 : 50);
      if (n == 300) begin
        // hold off until every owed result has come back
        start_i <= 1'b0;
        @(posedge clk_i);
        while (results_owed != 0) @(posedge clk_i);
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_sorted_software_timer_queue_top OK");
    end else begin
      $display("tb_sorted_software_timer_queue_top NOT OK");
    end
    $finish;
  end

endmodule
